### hdl/sbda_pkg.sv
// shared types and constants for the signed binary to decimal ascii converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sbda_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [3:0] BCD_LIMIT  = 4'd5;
    localparam logic [3:0] BCD_ADJUST = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
        logic emit_sign;
        logic skip;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic negative;
        logic step_last;
        logic top_zero;
        logic left_one;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

### hdl/sbda_ctrl.sv
// controller state machine: sequences load, double dabble steps and character output
// depends on sbda_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbda_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire sbda_pkg::t_status i_status,
    output sbda_pkg::t_cmd         o_cmd
);
    import sbda_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (i_status.step_last) begin
                    n_state = i_status.negative ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN: begin
                if (i_status.out_free) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (!i_status.top_zero || i_status.left_one) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free && i_status.left_one) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.load   = i_valid;
            end
            ST_CONV: begin
                o_cmd.shift = 1'b1;
            end
            ST_SIGN: begin
                o_cmd.emit_sign = i_status.out_free;
            end
            ST_SKIP: begin
                // drop leading zeros, always keep the final digit
                o_cmd.skip = i_status.top_zero && !i_status.left_one;
            end
            ST_EMIT: begin
                o_cmd.emit_digit = i_status.out_free;
            end
            default: begin
                o_ready = 1'b0;
                o_cmd   = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/sbda_dp.sv
// datapath: magnitude, double dabble shift register, digit counter and output register
// depends on sbda_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbda_dp #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic signed [VALUE_WIDTH-1:0] i_value,
    input  wire sbda_pkg::t_cmd         i_cmd,
    output sbda_pkg::t_status           o_status,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [7:0]                  o_character,
    output logic                        o_last
);
    import sbda_pkg::*;

    // decimal digits of 2^VALUE_WIDTH, 1233/4096 approximates log10(2)
    localparam int NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int STEP_W     = $clog2(VALUE_WIDTH + 1);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    logic [VALUE_WIDTH-1:0] r_bin;
    logic [BCD_W-1:0]       r_bcd;
    logic                   r_neg;
    logic [STEP_W-1:0]      r_step;
    logic [LEFT_W-1:0]      r_left;
    logic                   r_out_valid;
    logic [7:0]             r_char;
    logic                   r_last;

    logic [VALUE_WIDTH-1:0] w_raw;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic [BCD_W-1:0]       w_adj;
    logic [3:0]             w_top;

    assign w_raw = i_value;
    assign w_mag = w_raw[VALUE_WIDTH-1] ? (~w_raw + VALUE_WIDTH'(1)) : w_raw;
    assign w_top = r_bcd[BCD_W-1 -: 4];

    // add three to every digit of five or more before the shift
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            w_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= BCD_LIMIT) ?
                              (r_bcd[4*d +: 4] + BCD_ADJUST) : r_bcd[4*d +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_step <= STEP_W'(VALUE_WIDTH);
                r_left <= LEFT_W'(NUM_DIGITS);
            end else if (i_cmd.shift) begin
                r_step <= r_step - STEP_W'(1);
            end else if (i_cmd.skip || i_cmd.emit_digit) begin
                r_left <= r_left - LEFT_W'(1);
            end
            if (i_cmd.emit_sign || i_cmd.emit_digit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin <= w_mag;
            r_bcd <= '0;
            r_neg <= w_raw[VALUE_WIDTH-1];
        end else if (i_cmd.shift) begin
            r_bin <= {r_bin[VALUE_WIDTH-2:0], 1'b0};
            r_bcd <= {w_adj[BCD_W-2:0], r_bin[VALUE_WIDTH-1]};
        end else if (i_cmd.skip || i_cmd.emit_digit) begin
            r_bcd <= {r_bcd[BCD_W-5:0], 4'b0000};
        end
        if (i_cmd.emit_sign) begin
            r_char <= CHAR_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= CHAR_ZERO + {4'b0000, w_top};
            r_last <= (r_left == LEFT_W'(1));
        end
    end

    assign o_status.negative  = r_neg;
    assign o_status.step_last = (r_step == STEP_W'(1));
    assign o_status.top_zero  = (w_top == 4'd0);
    assign o_status.left_one  = (r_left == LEFT_W'(1));
    assign o_status.out_free  = !r_out_valid || i_ready;

    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule

`default_nettype wire

### hdl/signed_binary_to_decimal_ascii_top.sv
// Signed binary to decimal ascii converter. One request carries a signed two's complement
// value of VALUE_WIDTH bits; the block answers with its decimal text, one ascii character
// per output request, a leading '-' for negative values, no leading zeros, and o_last on
// the final digit. Requests are taken one at a time: the conversion runs VALUE_WIDTH
// double dabble steps (one per cycle), then drops the suppressed leading zeros of its
// N = floor(0.301*W)+1 digits, then sends each character when the output side is ready.
// The last character may wait in the output register while the next value is taken.
// depends on sbda_pkg, sbda_ctrl, sbda_dp
`timescale 1ns / 1ps
`default_nettype none

module signed_binary_to_decimal_ascii_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [7:0]                         o_character,
    output logic                               o_last
);
    import sbda_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    sbda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    sbda_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

### hdl/sbda_check.sv
// port level checks for the converter top level, attached by bind
// depends on sbda_pkg and signed_binary_to_decimal_ascii_top
`timescale 1ns / 1ps
`default_nettype none

module sbda_check (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_character,
    input wire logic       o_last
);
    import sbda_pkg::*;

    // a stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_character) && $stable(o_last))
        else $error("output character changed while stalled");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_character == CHAR_MINUS ||
                    (o_character >= CHAR_ZERO && o_character <= CHAR_ZERO + 8'd9))
        else $error("character outside minus and digits");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_character == CHAR_MINUS |-> !o_last)
        else $error("minus sign flagged as last");

    // one request at a time: ready drops after an accepted value
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second request taken during conversion");

endmodule

bind signed_binary_to_decimal_ascii_top sbda_check u_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_character (o_character),
    .o_last      (o_last)
);

`default_nettype wire
